// ===== src/rab_pkg.sv =====
// shared types and constants for the ray versus box slab test
`timescale 1ns / 1ps
`default_nettype none
package rab_pkg;

  // field widths
  localparam int unsigned CRD_W  = 32;
  localparam int unsigned DIR_W  = 18;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned EPS_W  = 17;
  localparam int unsigned T_W    = 32;
  localparam int unsigned QUO_W  = 32;

  localparam logic [EPS_W-1:0] EPS_RESET = 17'd7;

  // divider pipeline shape
  localparam int unsigned DIV_SPS    = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_SPS;
  localparam int unsigned DIV_LAT    = DIV_STAGES + 2;

  localparam logic signed [T_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [T_W-1:0] T_MIN = 32'sh8000_0000;

  typedef logic signed [T_W-1:0] dist_t;

  // per item axis flags that run beside the dividers
  typedef struct packed {
    logic [2:0] par;
    logic [2:0] pmiss;
  } side_t;

endpackage
`default_nettype wire

// ===== src/rab_axis_prep.sv =====
// per axis front end: plane offsets and parallel slab test
`timescale 1ns / 1ps
`default_nettype none
module rab_axis_prep import rab_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic signed [CRD_W-1:0]  origin_i,
  input  wire logic signed [DIR_W-1:0]  dir_i,
  input  wire logic signed [CRD_W-1:0]  box_min_i,
  input  wire logic signed [CRD_W-1:0]  box_max_i,
  input  wire logic [EPS_W-1:0]         eps_i,
  output logic signed [DIFF_W-1:0]      diff_lo_o,
  output logic signed [DIFF_W-1:0]      diff_hi_o,
  output logic signed [DIR_W-1:0]       dir_o,
  output logic                          par_o,
  output logic                          pmiss_o
);

  logic [DIR_W-1:0] mag;
  logic             par_d;
  logic             pmiss_d;

  // parallel test and slab containment
  always_comb begin
    mag     = dir_i[DIR_W-1] ? DIR_W'(-dir_i) : DIR_W'(dir_i);
    par_d   = (dir_i == '0) || (mag < DIR_W'(eps_i));
    pmiss_d = par_d && ((origin_i < box_min_i) || (origin_i > box_max_i));
  end

  always_ff @(posedge clk_i) begin
    diff_lo_o <= DIFF_W'(box_min_i) - DIFF_W'(origin_i);
    diff_hi_o <= DIFF_W'(box_max_i) - DIFF_W'(origin_i);
    dir_o     <= dir_i;
    par_o     <= par_d;
    pmiss_o   <= pmiss_d;
  end

endmodule
`default_nettype wire

// ===== src/rab_div.sv =====
// pipelined signed fixed point divider with 32 bit saturation
`timescale 1ns / 1ps
`default_nettype none
module rab_div import rab_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic signed [DIFF_W-1:0] diff_i,
  input  wire logic signed [DIR_W-1:0]  dir_i,
  output dist_t                         quo_o
);

  localparam int unsigned NUM_W    = DIFF_W + FRAC_BITS;
  localparam int unsigned DEN_SH_W = DIR_W + QUO_W;
  localparam int unsigned CMP_W    = (NUM_W > DEN_SH_W) ? NUM_W : DEN_SH_W;

  logic [NUM_W-1:0] rem_q [DIV_STAGES+1];
  logic [NUM_W-1:0] rem_d [DIV_STAGES];
  logic [DIR_W-1:0] den_q [DIV_STAGES+1];
  logic [QUO_W-1:0] quo_q [DIV_STAGES+1];
  logic [QUO_W-1:0] quo_d [DIV_STAGES];
  logic             neg_q [DIV_STAGES+1];
  logic             ovf_q [DIV_STAGES+1];

  logic [DIFF_W-1:0] mag_n;
  logic [DIR_W-1:0]  mag_d;
  logic [NUM_W-1:0]  num;
  logic              ovf;
  dist_t             sat_d;

  // magnitudes, sign and quotient overflow
  always_comb begin
    mag_n = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
    mag_d = dir_i[DIR_W-1] ? DIR_W'(-dir_i) : DIR_W'(dir_i);
    num   = {mag_n, {FRAC_BITS{1'b0}}};
    ovf   = CMP_W'(num) >= (CMP_W'(mag_d) << QUO_W);
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num;
    den_q[0] <= mag_d;
    quo_q[0] <= '0;
    neg_q[0] <= diff_i[DIFF_W-1] ^ dir_i[DIR_W-1];
    ovf_q[0] <= ovf;
  end

  // restoring steps, DIV_SPS quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    always_comb begin
      logic [CMP_W-1:0] r;
      logic [CMP_W-1:0] sh;
      logic [QUO_W-1:0] q;
      r = CMP_W'(rem_q[s]);
      q = quo_q[s];
      for (int j = 0; j < DIV_SPS; j++) begin
        sh = CMP_W'(den_q[s]) << (QUO_W - 1 - s * DIV_SPS - j);
        if (r >= sh) begin
          r = r - sh;
          q[QUO_W - 1 - s * DIV_SPS - j] = 1'b1;
        end
      end
      rem_d[s] = NUM_W'(r);
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d[s];
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= quo_d[s];
      neg_q[s+1] <= neg_q[s];
      ovf_q[s+1] <= ovf_q[s];
    end
  end

  // apply sign and clamp to the 32 bit range
  always_comb begin
    if (!neg_q[DIV_STAGES]) begin
      if (ovf_q[DIV_STAGES] || quo_q[DIV_STAGES][QUO_W-1]) begin
        sat_d = T_MAX;
      end else begin
        sat_d = dist_t'(quo_q[DIV_STAGES]);
      end
    end else begin
      if (ovf_q[DIV_STAGES] ||
          (quo_q[DIV_STAGES][QUO_W-1] && (|quo_q[DIV_STAGES][QUO_W-2:0]))) begin
        sat_d = T_MIN;
      end else begin
        sat_d = dist_t'(-quo_q[DIV_STAGES]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_o <= sat_d;
  end

endmodule
`default_nettype wire

// ===== src/rab_fold.sv =====
// orders plane distances, folds near and far, decides hit
`timescale 1ns / 1ps
`default_nettype none
module rab_fold import rab_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire dist_t t_lo_i [3],
  input  wire dist_t t_hi_i [3],
  input  wire side_t side_i,
  output logic       valid_o,
  output logic       hit_o,
  output dist_t      t_near_o,
  output dist_t      t_far_o
);

  dist_t near_a_d [3];
  dist_t far_a_d  [3];
  dist_t near_a_q [3];
  dist_t far_a_q  [3];
  logic  miss_a_q;
  logic  va_q;

  dist_t near_b_d;
  dist_t far_b_d;
  dist_t near_b_q;
  dist_t far_b_q;
  logic  miss_b_q;
  logic  vb_q;

  logic  miss_c;

  // order each axis pair, parallel axes stay neutral
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (side_i.par[a]) begin
        near_a_d[a] = T_MIN;
        far_a_d[a]  = T_MAX;
      end else if (t_lo_i[a] > t_hi_i[a]) begin
        near_a_d[a] = t_hi_i[a];
        far_a_d[a]  = t_lo_i[a];
      end else begin
        near_a_d[a] = t_lo_i[a];
        far_a_d[a]  = t_hi_i[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    near_a_q <= near_a_d;
    far_a_q  <= far_a_d;
    miss_a_q <= |side_i.pmiss;
  end

  // largest near and smallest far over the axes
  always_comb begin
    near_b_d = near_a_q[0];
    far_b_d  = far_a_q[0];
    for (int a = 1; a < 3; a++) begin
      if (near_a_q[a] > near_b_d) begin
        near_b_d = near_a_q[a];
      end
      if (far_a_q[a] < far_b_d) begin
        far_b_d = far_a_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    near_b_q <= near_b_d;
    far_b_q  <= far_b_d;
    miss_b_q <= miss_a_q;
  end

  // final hit decision, distances cleared on a miss
  assign miss_c = miss_b_q || (far_b_q < near_b_q) || far_b_q[T_W-1];

  always_ff @(posedge clk_i) begin
    hit_o    <= !miss_c;
    t_near_o <= miss_c ? '0 : near_b_q;
    t_far_o  <= miss_c ? '0 : far_b_q;
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      valid_o <= vb_q;
    end
  end

endmodule
`default_nettype wire

// ===== src/ray_aabb_slab_intersect.sv =====
// top level: ray versus axis-aligned box slab test
//
// Usage: drive one item (origin, direction, box bounds per axis, signed
// fixed point with FRAC_BITS fraction bits) with start high for one cycle.
// busy is held low, so an item is taken on every cycle that start is high.
// Each item yields one result: done_o is high for exactly one cycle with
// hit_o, t_near_o and t_far_o valid; both distances read zero on a miss.
// Each item passes through the per axis front end, the six pipelined
// dividers, one per box plane, with two quotient bits per stage by default,
// and the fold stages before done_o.
// Throughput is one item per cycle. Results come out in input order.
// The receiver cannot stall; it must take every result as it appears.
// parallel_epsilon is written through cfg_we_i / cfg_wdata_i and resets
// to 7; write it only while no item is in flight.
// Reset clears all valid bits, so no stray done_o follows reset.
`timescale 1ns / 1ps
`default_nettype none
module ray_aabb_slab_intersect import rab_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    cfg_we_i,
  input  wire logic [EPS_W-1:0]        cfg_wdata_i,
  input  wire logic signed [CRD_W-1:0] origin_x_i,
  input  wire logic signed [CRD_W-1:0] origin_y_i,
  input  wire logic signed [CRD_W-1:0] origin_z_i,
  input  wire logic signed [DIR_W-1:0] dir_x_i,
  input  wire logic signed [DIR_W-1:0] dir_y_i,
  input  wire logic signed [DIR_W-1:0] dir_z_i,
  input  wire logic signed [CRD_W-1:0] box_min_x_i,
  input  wire logic signed [CRD_W-1:0] box_max_x_i,
  input  wire logic signed [CRD_W-1:0] box_min_y_i,
  input  wire logic signed [CRD_W-1:0] box_max_y_i,
  input  wire logic signed [CRD_W-1:0] box_min_z_i,
  input  wire logic signed [CRD_W-1:0] box_max_z_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic signed [T_W-1:0]        t_near_o,
  output logic signed [T_W-1:0]        t_far_o
);

  logic [EPS_W-1:0] eps_q;

  logic signed [CRD_W-1:0] org   [3];
  logic signed [DIR_W-1:0] dir   [3];
  logic signed [CRD_W-1:0] bmin  [3];
  logic signed [CRD_W-1:0] bmax  [3];

  logic signed [DIFF_W-1:0] diff_lo [3];
  logic signed [DIFF_W-1:0] diff_hi [3];
  logic signed [DIR_W-1:0]  dir_p   [3];
  logic [2:0]               par_p;
  logic [2:0]               pmiss_p;

  dist_t t_lo [3];
  dist_t t_hi [3];

  logic  v_q    [DIV_LAT+1];
  side_t side_q [DIV_LAT];

  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign org[0]  = origin_x_i;
  assign org[1]  = origin_y_i;
  assign org[2]  = origin_z_i;
  assign dir[0]  = dir_x_i;
  assign dir[1]  = dir_y_i;
  assign dir[2]  = dir_z_i;
  assign bmin[0] = box_min_x_i;
  assign bmin[1] = box_min_y_i;
  assign bmin[2] = box_min_z_i;
  assign bmax[0] = box_max_x_i;
  assign bmax[1] = box_max_y_i;
  assign bmax[2] = box_max_z_i;

  // per axis front end and the two plane dividers
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rab_axis_prep u_prep (
      .clk_i     (clk_i),
      .origin_i  (org[a]),
      .dir_i     (dir[a]),
      .box_min_i (bmin[a]),
      .box_max_i (bmax[a]),
      .eps_i     (eps_q),
      .diff_lo_o (diff_lo[a]),
      .diff_hi_o (diff_hi[a]),
      .dir_o     (dir_p[a]),
      .par_o     (par_p[a]),
      .pmiss_o   (pmiss_p[a])
    );

    rab_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i  (clk_i),
      .diff_i (diff_lo[a]),
      .dir_i  (dir_p[a]),
      .quo_o  (t_lo[a])
    );

    rab_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i  (clk_i),
      .diff_i (diff_hi[a]),
      .dir_i  (dir_p[a]),
      .quo_o  (t_hi[a])
    );
  end

  // valid bits alongside the front end and dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIV_LAT; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v_q[0] <= start && !busy;
      for (int i = 1; i <= DIV_LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // axis flags delayed to meet the divider outputs
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{par: par_p, pmiss: pmiss_p};
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  rab_fold u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v_q[DIV_LAT]),
    .t_lo_i   (t_lo),
    .t_hi_i   (t_hi),
    .side_i   (side_q[DIV_LAT-1]),
    .valid_o  (done_o),
    .hit_o    (hit_o),
    .t_near_o (t_near_o),
    .t_far_o  (t_far_o)
  );

endmodule
`default_nettype wire

// ===== sim/ray_aabb_slab_intersect_tb.sv =====
// testbench for the ray versus axis-aligned box slab test
`timescale 1ns / 1ps
module ray_aabb_slab_intersect_tb;
  import rab_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = DIV_LAT + 4;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [CRD_W-1:0] org[3];
    logic signed [DIR_W-1:0] dir[3];
    logic signed [CRD_W-1:0] bmin[3];
    logic signed [CRD_W-1:0] bmax[3];
  } ray_box_t;

  typedef struct {
    logic  hit;
    dist_t t_near;
    dist_t t_far;
  } slab_res_t;

  // pending items carry a tag: an item, a config write, or a drain pause
  typedef enum logic [1:0] {K_RAY, K_EPS, K_DRAIN} kind_e;
  typedef struct {
    kind_e            kind;
    ray_box_t         ray;
    logic [EPS_W-1:0] eps;
  } pend_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic start = 1'b0, cfg_we_i = 1'b0;
  logic [EPS_W-1:0] cfg_wdata_i = '0;
  logic signed [CRD_W-1:0] ox = '0, oy = '0, oz = '0;
  logic signed [DIR_W-1:0] dx = '0, dy = '0, dz = '0;
  logic signed [CRD_W-1:0] nx = '0, xx = '0, ny = '0, xy = '0, nz = '0, xz = '0;
  logic busy, done_o, hit_o;
  logic signed [T_W-1:0] t_near_o, t_far_o;

  pend_t     pend_q[$];
  slab_res_t hit_q[$];
  logic [EPS_W-1:0] cur_eps = EPS_RESET;
  int  errors = 0;
  bit  stim_done = 1'b0;
  longint cycles = 0;

  ray_aabb_slab_intersect dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .origin_x_i(ox), .origin_y_i(oy), .origin_z_i(oz),
    .dir_x_i(dx), .dir_y_i(dy), .dir_z_i(dz),
    .box_min_x_i(nx), .box_max_x_i(xx), .box_min_y_i(ny),
    .box_max_y_i(xy), .box_min_z_i(nz), .box_max_z_i(xz),
    .done_o(done_o), .hit_o(hit_o), .t_near_o(t_near_o), .t_far_o(t_far_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // saturated plane distance
  function automatic longint plane_t(longint bound, longint org, longint d);
    longint q;
    q = ((bound - org) * (longint'(1) << FRAC)) / d;
    if (q > 64'sd2147483647) return 64'sd2147483647;
    if (q < -64'sd2147483648) return -64'sd2147483648;
    return q;
  endfunction

  function automatic slab_res_t slab_test(ray_box_t r, logic [EPS_W-1:0] eps);
    slab_res_t res;
    longint tn, tf, o, d, lo, hi, a, b, tmp, mag;
    bit miss;
    tn = -64'sd2147483648;
    tf = 64'sd2147483647;
    miss = 0;
    for (int ax = 0; ax < 3; ax++) begin
      o = r.org[ax]; d = r.dir[ax]; lo = r.bmin[ax]; hi = r.bmax[ax];
      mag = d < 0 ? -d : d;
      if (d == 0 || mag < longint'(eps)) begin
        if (o < lo || o > hi) miss = 1;
      end else begin
        a = plane_t(lo, o, d);
        b = plane_t(hi, o, d);
        if (a > b) begin
          tmp = a; a = b; b = tmp;
        end
        if (a > tn) tn = a;
        if (b < tf) tf = b;
      end
    end
    if (tf < tn || tf < 0) miss = 1;
    res.hit = !miss;
    res.t_near = miss ? '0 : dist_t'(tn);
    res.t_far = miss ? '0 : dist_t'(tf);
    return res;
  endfunction

  function automatic logic signed [CRD_W-1:0] rnd_crd();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'sh8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic signed [DIR_W-1:0] rnd_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 18'sd65536;
      2: return -18'sd65536;
      3: return $signed(18'($urandom_range(0, 20))) - 18'sd10;
      4: return 18'($urandom());
      default: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
    endcase
  endfunction

  // mostly boxes around the origin so that hits are common
  function automatic ray_box_t rnd_ray();
    ray_box_t r;
    logic signed [CRD_W-1:0] a, b;
    for (int ax = 0; ax < 3; ax++) begin
      r.org[ax] = rnd_crd();
      r.dir[ax] = rnd_dir();
      a = rnd_crd(); b = rnd_crd();
      if ($urandom_range(0, 9) != 0 && a > b) begin
        r.bmin[ax] = b; r.bmax[ax] = a;
      end else begin
        r.bmin[ax] = a; r.bmax[ax] = b;
      end
    end
    return r;
  endfunction

  function automatic ray_box_t mk_ray(int o, int d, int lo, int hi);
    ray_box_t r;
    for (int ax = 0; ax < 3; ax++) begin
      r.org[ax] = o; r.dir[ax] = DIR_W'(d); r.bmin[ax] = lo; r.bmax[ax] = hi;
    end
    return r;
  endfunction

  task automatic add_ray(ray_box_t r);
    pend_t p;
    p.kind = K_RAY; p.ray = r; p.eps = '0;
    pend_q.push_back(p);
  endtask

  task automatic add_eps(logic [EPS_W-1:0] e);
    pend_t p;
    p.kind = K_EPS; p.eps = e;
    pend_q.push_back(p);
  endtask

  // stimulus
  initial begin
    ray_box_t r;
    logic [EPS_W-1:0] eps_set[5];
    eps_set = '{17'd0, 17'd65536, 17'd7, 17'd300, 17'd1};
    // directed
    add_ray(mk_ray(0, 65536, -65536, 65536));
    add_ray(mk_ray(0, -65536, 65536, 131072));
    add_ray(mk_ray(0, 0, -5, 5));
    add_ray(mk_ray(10, 0, -5, 5));
    add_ray(mk_ray(5, 0, 5, 5));
    add_ray(mk_ray(0, 3, -5, 5));
    add_ray(mk_ray(0, 65536, 5, -5));
    add_ray(mk_ray(32'sh7FFF_FFFF, 1 <<< 10, 32'sh8000_0000, 32'sh7FFF_FFFF));
    add_ray(mk_ray(32'sh8000_0000, -65536, 32'sh8000_0000, 32'sh7FFF_FFFF));
    add_ray(mk_ray(0, 1 <<< 17, 100, 200));
    add_ray(mk_ray(0, (1 <<< 17) - 1, 100, 200));
    add_ray(mk_ray(-100, 65536, -100, -100));
    r = mk_ray(0, 65536, -65536, 65536); r.dir[1] = 0; r.dir[2] = -65536;
    add_ray(r);
    r = mk_ray(0, 65536, 65536, 131072); r.dir[1] = 7; r.dir[2] = 6;
    add_ray(r);
    add_eps(17'd0);
    add_ray(mk_ray(0, 0, -5, 5));
    add_ray(mk_ray(0, 1, -5, 5));
    add_eps(17'd65536);
    add_ray(mk_ray(0, 65535, -5, 5));
    add_ray(mk_ray(0, -65536, -5, 5));
    // random phases with a config write between
    for (int ph = 0; ph < 6; ph++) begin
      add_eps(ph == 5 ? 17'($urandom_range(0, 65536)) : eps_set[ph]);
      for (int i = 0; i < 200; i++) begin
        if (i == 100) begin
          pend_t p;
          p.kind = K_DRAIN;
          pend_q.push_back(p);
        end
        add_ray(rnd_ray());
      end
    end
  end

  // driver
  int  gap = 0;
  int  hold = 0;
  always @(posedge clk_i) begin
    pend_t p;
    logic  start_n;
    logic  we_n;
    start_n = 1'b0;
    we_n = 1'b0;
    if (rst_ni) begin
      if (hold > 0) begin
        hold <= hold - 1;
      end else if (gap > 0) begin
        gap <= gap - 1;
      end else if (pend_q.size() == 0) begin
        stim_done <= 1'b1;
      end else if (pend_q[0].kind == K_RAY) begin
        if (!busy) begin
          p = pend_q.pop_front();
          ox <= p.ray.org[0]; oy <= p.ray.org[1]; oz <= p.ray.org[2];
          dx <= p.ray.dir[0]; dy <= p.ray.dir[1]; dz <= p.ray.dir[2];
          nx <= p.ray.bmin[0]; xx <= p.ray.bmax[0];
          ny <= p.ray.bmin[1]; xy <= p.ray.bmax[1];
          nz <= p.ray.bmin[2]; xz <= p.ray.bmax[2];
          start_n = 1'b1;
          hit_q.push_back(slab_test(p.ray, cur_eps));
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
      end else if (hit_q.size() == 0 && !start) begin
        // idle: all expected results in, so act now and then hold off new items
        p = pend_q.pop_front();
        if (p.kind == K_EPS) begin
          we_n = 1'b1;
          cfg_wdata_i <= p.eps;
          cur_eps = p.eps;
        end
        hold <= LATENCY;
      end
    end
    start <= start_n;
    cfg_we_i <= we_n;
  end

  // monitor
  always @(posedge clk_i) begin
    slab_res_t e;
    if (rst_ni && done_o) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b near=%0d far=%0d",
                 $time, hit_o, t_near_o, t_far_o);
        errors++;
      end else begin
        e = hit_q.pop_front();
        if (hit_o !== e.hit || t_near_o !== e.t_near || t_far_o !== e.t_far) begin
          $display("%0t: mismatch exp hit=%0b near=%0d far=%0d got hit=%0b near=%0d far=%0d",
                   $time, e.hit, e.t_near, e.t_far, hit_o, t_near_o, t_far_o);
          errors++;
        end
      end
    end
  end

  // reset, end of run and timeout
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("ray_aabb_slab_intersect_tb: FAIL");
        $finish;
      end
      if (stim_done && hit_q.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk_i);
        if (errors == 0 && hit_q.size() == 0) begin
          $display("ray_aabb_slab_intersect_tb: PASS");
        end else begin
          $display("ray_aabb_slab_intersect_tb: FAIL");
        end
        $finish;
      end
    end
  end

endmodule

// ===== ray_aabb_slab_intersect.f =====
src/rab_pkg.sv
src/rab_axis_prep.sv
src/rab_div.sv
src/rab_fold.sv
src/ray_aabb_slab_intersect.sv
sim/ray_aabb_slab_intersect_tb.sv
